// ----- hdl/gcml_pkg.sv -----
// Shared types, constants and the fourth-power table for the gradient color map.
package gcml_pkg;

    localparam int LVL_W       = 18;
    localparam int COLOR_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int POW4_W      = 4 * COLOR_W;
    localparam int ROOT_STAGES = COLOR_W;
    // input register + blend + square + fourth power + scale + root stages
    localparam int PIPE_DEPTH  = 5 + ROOT_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_RED   = 3'd0,
        REG_START_GREEN = 3'd1,
        REG_START_BLUE  = 3'd2,
        REG_END_RED     = 3'd3,
        REG_END_GREEN   = 3'd4,
        REG_END_BLUE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] lo;
        logic [COLOR_W-1:0] hi;
    } chan_cfg_t;

    typedef logic [POW4_W-1:0] pow4_tab_t [2**COLOR_W];

    function automatic pow4_tab_t build_pow4();
        pow4_tab_t tab;
        for (int c = 0; c < 2**COLOR_W; c++)
        begin
            tab[c] = POW4_W'(c * c) * POW4_W'(c * c);
        end
        return tab;
    endfunction

    localparam pow4_tab_t POW4_TAB = build_pow4();

endpackage

// ----- hdl/gradient_color_map_lookup.sv -----
// Top level: gradient color map with fourth-root dimming, fully pipelined.
//
//  channel   signals                          request taken when
//  -------   -------------------------------  --------------------------
//  input     start, busy, level               start && !busy
//  result    done, red, green, blue           done (one cycle, no stall)
//  config    cfg_valid, cfg_ready,            cfg_valid && cfg_ready
//            cfg_index, cfg_data
//
// One request per clock; done rises together with the result, which is valid
// while done is high.
// Pipeline: input register, blend multiply, two squaring multiplies, index
// scale multiply, then one fourth-root bit per stage (8).
// busy and cfg_ready are always low/high: nothing in the pipe ever stalls.
// rst_n clears valid bits and loads the default colors (black to white).
// TABLE_SIZE must be a power of two.
module gradient_color_map_lookup
    import gcml_pkg::*;
#(
    parameter int TABLE_SIZE = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [LVL_W-1:0] level,
    output logic                 done,
    output logic [COLOR_W-1:0]   red,
    output logic [COLOR_W-1:0]   green,
    output logic [COLOR_W-1:0]   blue,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [COLOR_W-1:0] start_red_reg, start_green_reg, start_blue_reg;
    logic [COLOR_W-1:0] end_red_reg, end_green_reg, end_blue_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [IDX_W:0]     lvl_scaled;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   idx_reg;
    chan_cfg_t          cfg_r, cfg_g, cfg_b;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_red_reg   <= '0;
            start_green_reg <= '0;
            start_blue_reg  <= '0;
            end_red_reg     <= '1;
            end_green_reg   <= '1;
            end_blue_reg    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_RED:   start_red_reg   <= cfg_data;
                REG_START_GREEN: start_green_reg <= cfg_data;
                REG_START_BLUE:  start_blue_reg  <= cfg_data;
                REG_END_RED:     end_red_reg     <= cfg_data;
                REG_END_GREEN:   end_green_reg   <= cfg_data;
                REG_END_BLUE:    end_blue_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // index = level * N / 2^16, clamped to 0..N-1
    assign lvl_scaled = level[LVL_W-2 -: IDX_W+1];
    assign idx_next   = level[LVL_W-1]      ? '0 :
                        lvl_scaled[IDX_W]   ? '1 : lvl_scaled[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[PIPE_DEPTH-1];

    assign cfg_r = '{lo: start_red_reg,   hi: end_red_reg};
    assign cfg_g = '{lo: start_green_reg, hi: end_green_reg};
    assign cfg_b = '{lo: start_blue_reg,  hi: end_blue_reg};

    gcml_chan #(.IDX_W(IDX_W)) u_chan_r
    (
        .clk   (clk),
        .idx   (idx_reg),
        .cfg   (cfg_r),
        .shade (red)
    );

    gcml_chan #(.IDX_W(IDX_W)) u_chan_g
    (
        .clk   (clk),
        .idx   (idx_reg),
        .cfg   (cfg_g),
        .shade (green)
    );

    gcml_chan #(.IDX_W(IDX_W)) u_chan_b
    (
        .clk   (clk),
        .idx   (idx_reg),
        .cfg   (cfg_b),
        .shade (blue)
    );

endmodule

// ----- hdl/gcml_chan.sv -----
// One color channel: linear blend, fourth power, scaling and bitwise fourth root.
module gcml_chan
    import gcml_pkg::*;
#(
    parameter int IDX_W = 16
)
(
    input  logic               clk,
    input  logic [IDX_W-1:0]   idx,
    input  chan_cfg_t          cfg,
    output logic [COLOR_W-1:0] shade
);

    logic [IDX_W:0]        idx_inv;
    logic [IDX_W+9:0]      blend;
    logic [COLOR_W-1:0]    base_next;
    logic [COLOR_W-1:0]    base_reg;
    logic [IDX_W-1:0]      idx1_reg;
    logic [2*COLOR_W-1:0]  sq_next;
    logic [2*COLOR_W-1:0]  sq_reg;
    logic [IDX_W-1:0]      idx2_reg;
    logic [POW4_W-1:0]     q_next;
    logic [POW4_W-1:0]     q_reg;
    logic [IDX_W-1:0]      idx3_reg;
    logic [IDX_W+POW4_W-1:0] prod;
    logic [POW4_W-1:0]     t_next;
    logic [POW4_W-1:0]     t_reg;
    logic [COLOR_W-1:0]    root_m_reg [ROOT_STAGES];
    logic [POW4_W-1:0]     root_t_reg [ROOT_STAGES-1];

    // base = ((N - i) * lo + i * hi) / N, N a power of two
    assign idx_inv   = ((IDX_W+1)'(1) << IDX_W) - {1'b0, idx};
    assign blend     = (IDX_W+10)'(idx_inv) * (IDX_W+10)'(cfg.lo)
                     + (IDX_W+10)'(idx) * (IDX_W+10)'(cfg.hi);
    assign base_next = blend[IDX_W+COLOR_W-1:IDX_W];

    assign sq_next = (2*COLOR_W)'(base_reg) * (2*COLOR_W)'(base_reg);
    assign q_next  = POW4_W'(sq_reg) * POW4_W'(sq_reg);

    // threshold: m^4 <= floor(i * base^4 / N)
    assign prod   = (IDX_W+POW4_W)'(idx3_reg) * (IDX_W+POW4_W)'(q_reg);
    assign t_next = prod[IDX_W+POW4_W-1:IDX_W];

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        idx1_reg <= idx;
        sq_reg   <= sq_next;
        idx2_reg <= idx1_reg;
        q_reg    <= q_next;
        idx3_reg <= idx2_reg;
        t_reg    <= t_next;
    end

    // one result bit per stage, MSB first
    for (genvar g = 0; g < ROOT_STAGES; g++)
    begin : g_root
        logic [COLOR_W-1:0] m_in;
        logic [POW4_W-1:0]  t_in;
        logic [COLOR_W-1:0] cand;
        logic [COLOR_W-1:0] m_next;

        if (g == 0)
        begin : g_first
            assign m_in = '0;
            assign t_in = t_reg;
        end
        else
        begin : g_rest
            assign m_in = root_m_reg[g-1];
            assign t_in = root_t_reg[g-1];
        end

        assign cand   = m_in | (COLOR_W'(1) << (ROOT_STAGES - 1 - g));
        assign m_next = (POW4_TAB[cand] <= t_in) ? cand : m_in;

        always_ff @(posedge clk)
        begin
            root_m_reg[g] <= m_next;
        end

        if (g < ROOT_STAGES - 1)
        begin : g_tcarry
            always_ff @(posedge clk)
            begin
                root_t_reg[g] <= t_in;
            end
        end
    end

    assign shade = root_m_reg[ROOT_STAGES-1];

endmodule

// ----- hdl/gcml_checker.sv -----
// Port-level checks for the gradient color map, bound to the top level.
module gcml_checker
    import gcml_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [LVL_W-1:0]     level,
    input logic                 done,
    input logic [COLOR_W-1:0]   red,
    input logic [COLOR_W-1:0]   green,
    input logic [COLOR_W-1:0]   blue,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [COLOR_W-1:0]   cfg_data
);

    // every request produces a result after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("request without result");

    // no result without a request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without request");

    // zero or negative level gives black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (level[LVL_W-1] || level == '0))
            |-> ##PIPE_DEPTH (red == '0 && green == '0 && blue == '0))
        else $error("nonzero color at bottom of gradient");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write held off");

endmodule

bind gradient_color_map_lookup gcml_checker u_gcml_checker (.*);
